/* sv/npc_pkg.sv */
// ----------------------------------------------------------------------------
// npc_pkg
// Shared types, constants and the palette ROM for the nearest palette color
// core.
// ----------------------------------------------------------------------------
package npc_pkg;

    localparam int CHAN_W             = 8;
    localparam int SQ_W               = 2 * CHAN_W;
    localparam int DIST_W             = 18;
    localparam int IDX_W              = 5;
    localparam int ROM_ENTRIES        = 22;
    localparam int PALETTE_ENTRIES_DEF = 22;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pixel_t;

    typedef struct packed {
        logic [IDX_W-1:0]  color_index;
        logic [DIST_W-1:0] distance_squared;
    } match_t;

    // Entry request from the sequencer to the distance unit
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] index;
    } issue_t;

    // Finished distance from the distance unit
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] dist_sq;
    } dist_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_OUT
    } state_t;

    // Palette: white, black, maroon, red, pink, brown, orange, coral, olive,
    // yellow, beige, lime, green, mint, teal, cyan, navy, blue, purple,
    // lavender, magenta, grey. Teal and navy share the same color.
    function automatic pixel_t palette_rom(input logic [IDX_W-1:0] idx);
        pixel_t c;
        case (idx)
            5'd0:    c = '{8'd255, 8'd255, 8'd255};
            5'd1:    c = '{8'd0,   8'd0,   8'd0  };
            5'd2:    c = '{8'd128, 8'd0,   8'd0  };
            5'd3:    c = '{8'd255, 8'd0,   8'd0  };
            5'd4:    c = '{8'd255, 8'd200, 8'd220};
            5'd5:    c = '{8'd170, 8'd110, 8'd40 };
            5'd6:    c = '{8'd255, 8'd150, 8'd0  };
            5'd7:    c = '{8'd255, 8'd215, 8'd180};
            5'd8:    c = '{8'd128, 8'd128, 8'd0  };
            5'd9:    c = '{8'd255, 8'd235, 8'd0  };
            5'd10:   c = '{8'd255, 8'd250, 8'd200};
            5'd11:   c = '{8'd190, 8'd255, 8'd0  };
            5'd12:   c = '{8'd0,   8'd190, 8'd0  };
            5'd13:   c = '{8'd170, 8'd255, 8'd195};
            5'd14:   c = '{8'd0,   8'd0,   8'd128};
            5'd15:   c = '{8'd100, 8'd255, 8'd255};
            5'd16:   c = '{8'd0,   8'd0,   8'd128};
            5'd17:   c = '{8'd67,  8'd133, 8'd255};
            5'd18:   c = '{8'd130, 8'd0,   8'd150};
            5'd19:   c = '{8'd230, 8'd190, 8'd255};
            5'd20:   c = '{8'd255, 8'd0,   8'd255};
            5'd21:   c = '{8'd128, 8'd128, 8'd128};
            default: c = '{8'd0,   8'd0,   8'd0  };
        endcase
        return c;
    endfunction

endpackage

/* sv/npc_dist_unit.sv */
// ----------------------------------------------------------------------------
// npc_dist_unit
// Shared two-stage distance unit: squares the channel differences to one
// palette entry, then sums them. Accepts one entry per cycle.
// ----------------------------------------------------------------------------
module npc_dist_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  npc_pkg::pixel_t sample,
    input  npc_pkg::issue_t issue,
    output npc_pkg::dist_t  result
);

    npc_pkg::pixel_t              entry;
    logic [npc_pkg::CHAN_W-1:0]   dr;
    logic [npc_pkg::CHAN_W-1:0]   dg;
    logic [npc_pkg::CHAN_W-1:0]   db;

    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic [npc_pkg::IDX_W-1:0]    s1_index_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_r_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_g_reg;
    logic [npc_pkg::SQ_W-1:0]     sq_b_reg;

    logic                         s2_valid_reg;
    logic                         s2_last_reg;
    logic [npc_pkg::IDX_W-1:0]    s2_index_reg;
    logic [npc_pkg::DIST_W-1:0]   dist_reg;
    logic [npc_pkg::DIST_W-1:0]   dist_next;

    assign entry = npc_pkg::palette_rom(issue.index);
    assign dr = (sample.red   > entry.red)   ? sample.red   - entry.red
                                             : entry.red   - sample.red;
    assign dg = (sample.green > entry.green) ? sample.green - entry.green
                                             : entry.green - sample.green;
    assign db = (sample.blue  > entry.blue)  ? sample.blue  - entry.blue
                                             : entry.blue  - sample.blue;

    assign dist_next = npc_pkg::DIST_W'(sq_r_reg) + npc_pkg::DIST_W'(sq_g_reg)
                     + npc_pkg::DIST_W'(sq_b_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue.valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_last_reg  <= issue.last;
        s1_index_reg <= issue.index;
        sq_r_reg     <= npc_pkg::SQ_W'(dr) * npc_pkg::SQ_W'(dr);
        sq_g_reg     <= npc_pkg::SQ_W'(dg) * npc_pkg::SQ_W'(dg);
        sq_b_reg     <= npc_pkg::SQ_W'(db) * npc_pkg::SQ_W'(db);
        s2_last_reg  <= s1_last_reg;
        s2_index_reg <= s1_index_reg;
        dist_reg     <= dist_next;
    end

    assign result.valid   = s2_valid_reg;
    assign result.last    = s2_last_reg;
    assign result.index   = s2_index_reg;
    assign result.dist_sq = dist_reg;

endmodule

/* sv/npc_ctrl.sv */
// ----------------------------------------------------------------------------
// npc_ctrl
// Sequencer: takes a sample, walks the palette through the distance unit,
// keeps the running minimum and holds the result word until it is taken.
// ----------------------------------------------------------------------------
module npc_ctrl
#(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  npc_pkg::pixel_t sample,
    input  logic            sample_valid,
    output logic            sample_ready,
    output npc_pkg::match_t match,
    output logic            match_valid,
    input  logic            match_ready,
    output npc_pkg::pixel_t held_sample,
    output npc_pkg::issue_t issue,
    input  npc_pkg::dist_t  result
);

    localparam int SCAN_COUNT = (PALETTE_ENTRIES > npc_pkg::ROM_ENTRIES)
                              ? npc_pkg::ROM_ENTRIES : PALETTE_ENTRIES;
    localparam logic [npc_pkg::IDX_W-1:0] LAST_IDX = npc_pkg::IDX_W'(SCAN_COUNT - 1);

    npc_pkg::state_t              state_reg;
    npc_pkg::state_t              state_next;
    logic [npc_pkg::IDX_W-1:0]    idx_reg;
    logic [npc_pkg::IDX_W-1:0]    idx_next;
    npc_pkg::pixel_t              sample_reg;
    logic [npc_pkg::IDX_W-1:0]    best_idx_reg;
    logic [npc_pkg::DIST_W-1:0]   best_dist_reg;
    logic                         take_best;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            npc_pkg::ST_IDLE:
            begin
                if (sample_valid)
                    state_next = npc_pkg::ST_SCAN;
            end
            npc_pkg::ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                    state_next = npc_pkg::ST_DRAIN;
            end
            npc_pkg::ST_DRAIN:
            begin
                if (result.valid && result.last)
                    state_next = npc_pkg::ST_OUT;
            end
            npc_pkg::ST_OUT:
            begin
                if (match_ready)
                    state_next = npc_pkg::ST_IDLE;
            end
            default: state_next = npc_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        sample_ready = 1'b0;
        match_valid  = 1'b0;
        issue.valid  = 1'b0;
        issue.last   = (idx_reg == LAST_IDX);
        issue.index  = idx_reg;
        case (state_reg)
            npc_pkg::ST_IDLE:  sample_ready = 1'b1;
            npc_pkg::ST_SCAN:  issue.valid  = 1'b1;
            npc_pkg::ST_DRAIN: ;
            npc_pkg::ST_OUT:   match_valid  = 1'b1;
            default: ;
        endcase
    end

    assign idx_next    = (state_reg == npc_pkg::ST_SCAN) ? idx_reg + 1'b1 : '0;

    // First entry always seeds the minimum; later ones replace only if strictly closer
    assign take_best = result.valid
                    && ((result.index == '0) || (result.dist_sq < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= npc_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
            sample_reg <= sample;
        if (take_best)
        begin
            best_idx_reg  <= result.index;
            best_dist_reg <= result.dist_sq;
        end
    end

    assign held_sample            = sample_reg;
    assign match.color_index      = best_idx_reg;
    assign match.distance_squared = best_dist_reg;

endmodule

/* sv/nearest_palette_color_core.sv */
// ----------------------------------------------------------------------------
// nearest_palette_color_core
// Nearest palette color match of an RGB sample by squared Euclidean distance.
// ----------------------------------------------------------------------------
// One sample word in, one match word out. The core holds the sample, feeds
// one palette entry per cycle into a two-stage square-and-sum distance unit
// and keeps the running minimum (earliest entry wins ties). The walk covers
// min(PALETTE_ENTRIES, 22) ROM entries, and the match follows the last one
// out of the unit's two stages; sample_ready stays low from accept until
// the match word is taken, so a new sample is not accepted before the
// match of the last one has been taken.
module nearest_palette_color_core
#(
    parameter int PALETTE_ENTRIES = npc_pkg::PALETTE_ENTRIES_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  npc_pkg::pixel_t sample,
    input  logic            sample_valid,
    output logic            sample_ready,
    output npc_pkg::match_t match,
    output logic            match_valid,
    input  logic            match_ready
);

    npc_pkg::pixel_t held_sample;
    npc_pkg::issue_t issue;
    npc_pkg::dist_t  result;

    npc_ctrl #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .match        (match),
        .match_valid  (match_valid),
        .match_ready  (match_ready),
        .held_sample  (held_sample),
        .issue        (issue),
        .result       (result)
    );

    npc_dist_unit u_dist (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (held_sample),
        .issue  (issue),
        .result (result)
    );

endmodule
